>>> sv/ktlp_pkg.sv
// Package: widths, types and codes shared by the keyed table blocks.
`timescale 1ns / 1ps

package ktlp_pkg;

    localparam int KEY_BITS    = 10;
    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 16;
    localparam int TABLE_DEPTH = 1 << KEY_BITS;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic [KEY_BITS-1:0]          key_t;
    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [COUNT_BITS-1:0]        count_t;
    typedef logic [QPTR_BITS-1:0]         qptr_t;
    typedef logic [QPTR_BITS:0]           qcnt_t;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_MODIFY = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_FIND   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EXISTS = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } bk_state_t;

    typedef struct packed {
        req_type_t req_type;
        key_t      key;
        value_t    value;
    } req_t;

    // one table row: presence, lookup count, stored value
    typedef struct packed {
        logic   valid;
        count_t count;
        value_t value;
    } entry_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        req_t req;
    } q_head_t;

    // back end status toward the front
    typedef struct packed {
        logic clearing;
        logic pop;
    } bk_stat_t;

endpackage

>>> sv/ktlp_req_if.sv
// Request channel interface: valid/ready plus request payload.
`timescale 1ns / 1ps

interface ktlp_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    ktlp_pkg::key_t    key;
    ktlp_pkg::value_t  value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

>>> sv/ktlp_rsp_if.sv
// Result channel interface: valid/ready plus result payload.
`timescale 1ns / 1ps

interface ktlp_rsp_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    ktlp_pkg::value_t  read_value;
    logic              popular_valid;
    ktlp_pkg::key_t    top_key;

    modport source (output valid, output status, output read_value, output popular_valid,
                    output top_key, input ready);
    modport sink   (input valid, input status, input read_value, input popular_valid,
                    input top_key, output ready);
endinterface

>>> sv/ktlp_front.sv
// Front end: takes requests and holds them in a short queue for the back end.
`timescale 1ns / 1ps

module ktlp_front (
    input  logic                clk,
    input  logic                rst_n,
    ktlp_req_if.sink            req,
    input  ktlp_pkg::bk_stat_t  bk_stat,
    output ktlp_pkg::q_head_t   q_head
);

    ktlp_pkg::req_t  q_mem_reg [ktlp_pkg::QUEUE_DEPTH];
    ktlp_pkg::qptr_t wr_ptr_reg, wr_ptr_next;
    ktlp_pkg::qptr_t rd_ptr_reg, rd_ptr_next;
    ktlp_pkg::qcnt_t cnt_reg, cnt_next;
    logic            push;
    ktlp_pkg::req_t  in_req;

    // no requests taken while the table is being cleared
    assign req.ready = (cnt_reg != ktlp_pkg::qcnt_t'(ktlp_pkg::QUEUE_DEPTH))
                       && !bk_stat.clearing;
    assign push      = req.valid && req.ready;

    always_comb
    begin
        in_req.req_type = ktlp_pkg::req_type_t'(req.req_type);
        in_req.key      = req.key;
        in_req.value    = req.value;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = bk_stat.pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !bk_stat.pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && bk_stat.pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_req;
        end
    end

    assign q_head.valid = (cnt_reg != '0);
    assign q_head.req   = q_mem_reg[rd_ptr_reg];

endmodule

>>> sv/ktlp_back.sv
// Back end: table memory, read-modify-write sequencer, popularity argmax, result register.
`timescale 1ns / 1ps

module ktlp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ktlp_pkg::q_head_t   q_head,
    output ktlp_pkg::bk_stat_t  bk_stat,
    ktlp_rsp_if.source          rsp
);

    ktlp_pkg::entry_t    mem [ktlp_pkg::TABLE_DEPTH];
    ktlp_pkg::entry_t    rd_data_reg;

    ktlp_pkg::bk_state_t state_reg, state_next;
    ktlp_pkg::key_t      clr_addr_reg, clr_addr_next;
    ktlp_pkg::req_t      cur_reg;
    ktlp_pkg::key_t      best_key_reg, best_key_next;
    ktlp_pkg::count_t    best_count_reg, best_count_next;

    logic                out_valid_reg, out_valid_next;
    ktlp_pkg::status_t   out_status_reg;
    ktlp_pkg::value_t    out_value_reg;
    logic                out_pop_valid_reg;
    ktlp_pkg::key_t      out_pop_key_reg;

    logic                rd_en, wr_en, load_cur, out_load, out_free;
    ktlp_pkg::key_t      wr_addr;
    ktlp_pkg::entry_t    wr_data, new_entry;
    ktlp_pkg::status_t   status;
    ktlp_pkg::value_t    rd_value;
    ktlp_pkg::count_t    cnt_inc;

    assign out_free = !out_valid_reg || rsp.ready;

    // request execution on the registered table row
    always_comb
    begin
        new_entry       = rd_data_reg;
        status          = ktlp_pkg::ST_OK;
        rd_value        = '0;
        best_key_next   = best_key_reg;
        best_count_next = best_count_reg;
        cnt_inc         = (rd_data_reg.count == '1) ? rd_data_reg.count
                          : ktlp_pkg::count_t'(rd_data_reg.count + 1'b1);
        case (cur_reg.req_type)
            ktlp_pkg::REQ_INSERT:
            begin
                if (rd_data_reg.valid)
                begin
                    status = ktlp_pkg::ST_EXISTS;
                end
                else
                begin
                    new_entry.valid = 1'b1;
                    new_entry.value = cur_reg.value;
                end
            end
            ktlp_pkg::REQ_MODIFY:
            begin
                if (rd_data_reg.valid)
                begin
                    new_entry.value = cur_reg.value;
                end
                else
                begin
                    status = ktlp_pkg::ST_ABSENT;
                end
            end
            ktlp_pkg::REQ_DELETE:
            begin
                if (rd_data_reg.valid)
                begin
                    new_entry.valid = 1'b0;
                end
                else
                begin
                    status = ktlp_pkg::ST_ABSENT;
                end
            end
            ktlp_pkg::REQ_FIND:
            begin
                new_entry.count = cnt_inc;
                if (cnt_inc > best_count_reg
                    || (cnt_inc == best_count_reg && cur_reg.key < best_key_reg))
                begin
                    best_count_next = cnt_inc;
                    best_key_next   = cur_reg.key;
                end
                if (rd_data_reg.valid)
                begin
                    rd_value = rd_data_reg.value;
                end
                else
                begin
                    status = ktlp_pkg::ST_ABSENT;
                end
            end
            default:
            begin
                status = ktlp_pkg::ST_OK;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        load_cur      = 1'b0;
        out_load      = 1'b0;
        wr_addr       = cur_reg.key;
        wr_data       = new_entry;
        case (state_reg)
            ktlp_pkg::BK_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    state_next = ktlp_pkg::BK_IDLE;
                end
            end
            ktlp_pkg::BK_IDLE:
            begin
                if (q_head.valid)
                begin
                    rd_en      = 1'b1;
                    load_cur   = 1'b1;
                    state_next = ktlp_pkg::BK_EXEC;
                end
            end
            ktlp_pkg::BK_EXEC:
            begin
                if (out_free)
                begin
                    wr_en      = 1'b1;
                    out_load   = 1'b1;
                    state_next = ktlp_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ktlp_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ktlp_pkg::BK_CLEAR;
            clr_addr_reg   <= '0;
            best_key_reg   <= '0;
            best_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                best_key_reg   <= best_key_next;
                best_count_reg <= best_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_cur)
        begin
            cur_reg <= q_head.req;
        end
        if (out_load)
        begin
            out_status_reg    <= status;
            out_value_reg     <= rd_value;
            out_pop_valid_reg <= (best_count_next != '0);
            out_pop_key_reg   <= (best_count_next != '0) ? best_key_next : '0;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[q_head.req.key];
        end
    end

    assign bk_stat.clearing = (state_reg == ktlp_pkg::BK_CLEAR);
    assign bk_stat.pop      = load_cur;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.read_value    = out_value_reg;
    assign rsp.popular_valid = out_pop_valid_reg;
    assign rsp.top_key       = out_pop_key_reg;

endmodule

>>> sv/keyed_table_with_lookup_popularity_core.sv
// Top level: keyed value table with per-key lookup counters and popularity tracking.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-----------------------------------------------
//  req     | in  | valid/ready | req_type[1:0], key[9:0], value[31:0] signed
//  rsp     | out | valid/ready | status[1:0], read_value[31:0] signed,
//          |     |             | popular_valid, top_key[9:0]
//
// For each request the back end reads the table row (valid, count, value) from
// the synchronous table memory, then, once the result register is free, writes it
// back and loads the result register. It takes no new request before that.
// After reset a clearing pass sweeps all 1024 rows, one per cycle;
// req.ready stays low until it finishes. A 2-entry request queue keeps the input
// side moving while the back end waits on a stalled rsp.ready.
`timescale 1ns / 1ps

module keyed_table_with_lookup_popularity_core (
    input  logic        clk,
    input  logic        rst_n,
    ktlp_req_if.sink    req,
    ktlp_rsp_if.source  rsp
);

    ktlp_pkg::q_head_t  q_head;
    ktlp_pkg::bk_stat_t bk_stat;

    ktlp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .bk_stat (bk_stat),
        .q_head  (q_head)
    );

    ktlp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .bk_stat (bk_stat),
        .rsp     (rsp)
    );

    // nothing taken in while rows are still being cleared
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.clearing |-> !req.ready)
        else $error("request accepted during clearing pass");

    // clearing pass runs once after reset and never restarts
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !bk_stat.clearing |=> !bk_stat.clearing)
        else $error("clearing pass restarted");

    // back end never pops twice in a row (read, then write back)
    a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.pop |=> !bk_stat.pop)
        else $error("back end popped on consecutive cycles");

    // no popularity yet means the reported key is zero
    a_pop_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.popular_valid) |-> (rsp.top_key == '0))
        else $error("top_key nonzero without popular_valid");

endmodule
